// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the gain and filter chain.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PGHL_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("property violated");
`define PGHL_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");
`else
`define PGHL_ASSERT(lbl, clk, rstn, prop)
`define PGHL_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ===== rtl/pghl_pkg.sv =====
// Shared constants for the PCM gain, high-pass and low-pass chain.
`default_nettype none
package pghl_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COEF_W           = 16;
    localparam int FRAC_BITS        = 16;
    localparam int GAIN_FRAC_BITS   = 12;
    localparam int CFG_IDX_W        = 2;

    localparam logic [COEF_W-1:0] GAIN_RESET = 16'd4096;
    localparam logic [COEF_W-1:0] HPF_RESET  = 16'd65535;
    localparam logic [COEF_W-1:0] LPF_RESET  = 16'd65535;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN = 2'd0,
        CFG_HPF  = 2'd1,
        CFG_LPF  = 2'd2
    } cfg_idx_t;

endpackage
`default_nettype wire

// ===== rtl/pghl_mul.sv =====
// Shared registered multiplier: signed sample-side operand times unsigned coefficient.
`default_nettype none
module pghl_mul
    import pghl_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  wire logic                                   clk,
    input  wire logic signed [SAMPLE_WIDTH+1:0]         op_a,
    input  wire logic        [COEF_W-1:0]               op_b,
    output logic signed      [SAMPLE_WIDTH+COEF_W+2:0]  prod
);

    logic signed [SAMPLE_WIDTH+COEF_W+2:0] prod_reg;

    // Multiply and register; the coefficient is zero-extended to stay positive
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * $signed({1'b0, op_b});
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

// ===== rtl/pcm_gain_highpass_lowpass_chain.sv =====
// Top level: gain with saturation, one-pole high-pass and one-pole low-pass.
//
//  channel   | direction | data                                | handshake
//  s_axis    | in        | tdata: sample_in; tuser: start_req  | tvalid/tready
//  m_axis    | out       | tdata: sample_out; tuser: clipped   | tvalid/tready
//  cfg       | in        | cfg_index, cfg_data                 | cfg_valid/cfg_ready
//
//  Each sample makes four passes through the single shared multiplier (gain,
//  high-pass, low-pass low half, low-pass high half), with the rounding and
//  accumulate steps between them; no new sample is taken until the last is done.
//  The result sits in an output register; a stalled output holds the sequencer
//  in its last step until the register frees. Reset (rst_n, async) clears the
//  filter state and loads the register defaults; start_req clears the filters too.
`default_nettype none
`include "assert_macros.svh"
module pcm_gain_highpass_lowpass_chain
    import pghl_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,  // [W-1:0] sample_in
    input  wire logic                           s_axis_tuser,  // [0] start_req
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_axis_tdata,  // [W-1:0] sample_out
    output logic                                m_axis_tuser,  // [0] clipped
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]           cfg_index,
    input  wire logic [COEF_W-1:0]              cfg_data
);

    localparam int W    = SAMPLE_WIDTH;
    localparam int TDW  = ((W + 7) / 8) * 8;
    localparam int AW   = W + 2;
    localparam int PW   = AW + COEF_W + 1;
    localparam int FW   = PW + FRAC_BITS;
    localparam int ACCW = W + FRAC_BITS + 1;
    localparam int DW   = W + FRAC_BITS + 2;

    localparam logic signed [PW-1:0] PMAX = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [PW-1:0] PMIN = {{(PW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [PW-1:0] G_RND = PW'((1 << GAIN_FRAC_BITS) - 1);
    localparam logic signed [PW-1:0] F_RND_P = PW'((1 << FRAC_BITS) - 1);
    localparam logic signed [FW-1:0] F_RND_F = FW'((1 << FRAC_BITS) - 1);
    localparam logic signed [ACCW-1:0] F_RND_A = ACCW'((1 << FRAC_BITS) - 1);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_MUL_GAIN = 9'b000000010,
        ST_HP_PREP  = 9'b000000100,
        ST_MUL_HP   = 9'b000001000,
        ST_LP_PREP  = 9'b000010000,
        ST_MUL_LO   = 9'b000100000,
        ST_MUL_HI   = 9'b001000000,
        ST_LP_ACC   = 9'b010000000,
        ST_LP_OUT   = 9'b100000000
    } state_t;

    // Clamp a wide signed value to the sample range
    function automatic logic signed [W-1:0] sat(input logic signed [PW-1:0] v);
        logic signed [W-1:0] r;
        if (v > PMAX)
            r = PMAX[W-1:0];
        else if (v < PMIN)
            r = PMIN[W-1:0];
        else
            r = v[W-1:0];
        return r;
    endfunction

    state_t state_reg, state_next;

    logic [COEF_W-1:0] gain_reg, hpf_reg, lpf_reg;

    logic signed [W-1:0]    x_reg;
    logic signed [W-1:0]    amp_reg;
    logic                   clip_reg;
    logic signed [AW-1:0]   d_reg;
    logic signed [DW-1:0]   diff_reg;
    logic signed [PW-1:0]   lo_reg;
    logic signed [W-1:0]    hp_in_reg;
    logic signed [W-1:0]    hp_out_reg;
    logic signed [ACCW-1:0] acc_reg;

    logic           m_valid_reg;
    logic [TDW-1:0] m_data_reg;
    logic           m_user_reg;

    logic signed [AW-1:0]   mul_a;
    logic [COEF_W-1:0]      mul_b;
    logic signed [PW-1:0]   prod;

    logic signed [PW-1:0]   gain_q;
    logic signed [W-1:0]    amp;
    logic                   amp_clip;
    logic signed [AW-1:0]   hp_sum;
    logic signed [PW-1:0]   hp_q;
    logic signed [W-1:0]    hp_val;
    logic signed [DW-1:0]   lp_diff;
    logic signed [FW-1:0]   lp_full;
    logic signed [FW-1:0]   lp_q;
    logic signed [ACCW-1:0] acc_int;

    logic accept;
    logic out_free;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;

    // Select multiplier operands for the current step
    always_comb
    begin
        case (state_reg)
            ST_MUL_GAIN:
            begin
                mul_a = AW'(x_reg);
                mul_b = gain_reg;
            end
            ST_MUL_HP:
            begin
                mul_a = d_reg;
                mul_b = hpf_reg;
            end
            ST_MUL_LO:
            begin
                mul_a = $signed(AW'(diff_reg[FRAC_BITS-1:0]));
                mul_b = lpf_reg;
            end
            ST_MUL_HI:
            begin
                mul_a = diff_reg[DW-1:FRAC_BITS];
                mul_b = lpf_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    pghl_mul #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // Gain: drop 12 fraction bits toward zero, then saturate
    assign gain_q   = (prod + (prod[PW-1] ? G_RND : PW'(0))) >>> GAIN_FRAC_BITS;
    assign amp      = sat(gain_q);
    assign amp_clip = (gain_q > PMAX) || (gain_q < PMIN);
    assign hp_sum   = AW'(hp_out_reg) + AW'(amp) - AW'(hp_in_reg);

    // High-pass: drop 16 fraction bits toward zero, then saturate
    assign hp_q    = (prod + (prod[PW-1] ? F_RND_P : PW'(0))) >>> FRAC_BITS;
    assign hp_val  = sat(hp_q);
    assign lp_diff = DW'($signed({hp_val, {FRAC_BITS{1'b0}}})) - DW'(acc_reg);

    // Low-pass: recombine the two partial products, drop fraction toward zero
    assign lp_full = (FW'(prod) <<< FRAC_BITS) + FW'(lo_reg);
    assign lp_q    = (lp_full + (lp_full[FW-1] ? F_RND_F : FW'(0))) >>> FRAC_BITS;
    assign acc_int = (acc_reg + (acc_reg[ACCW-1] ? F_RND_A : ACCW'(0))) >>> FRAC_BITS;

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (accept) state_next = ST_MUL_GAIN;
            ST_MUL_GAIN: state_next = ST_HP_PREP;
            ST_HP_PREP:  state_next = ST_MUL_HP;
            ST_MUL_HP:   state_next = ST_LP_PREP;
            ST_LP_PREP:  state_next = ST_MUL_LO;
            ST_MUL_LO:   state_next = ST_MUL_HI;
            ST_MUL_HI:   state_next = ST_LP_ACC;
            ST_LP_ACC:   state_next = ST_LP_OUT;
            ST_LP_OUT:   if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Control, configuration and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            gain_reg    <= GAIN_RESET;
            hpf_reg     <= HPF_RESET;
            lpf_reg     <= LPF_RESET;
            hp_in_reg   <= '0;
            hp_out_reg  <= '0;
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_GAIN: gain_reg <= cfg_data;
                    CFG_HPF:  hpf_reg  <= cfg_data;
                    CFG_LPF:  lpf_reg  <= cfg_data;
                    default:  ;
                endcase
            end

            // Clear filter history on a start mark
            if (accept && s_axis_tuser)
            begin
                hp_in_reg  <= '0;
                hp_out_reg <= '0;
                acc_reg    <= '0;
            end

            if (state_reg == ST_LP_PREP)
            begin
                hp_in_reg  <= amp_reg;
                hp_out_reg <= hp_val;
            end

            if (state_reg == ST_LP_ACC)
                acc_reg <= acc_reg + lp_q[ACCW-1:0];

            if (state_reg == ST_LP_OUT && out_free)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Datapath holding registers
    always_ff @(posedge clk)
    begin
        if (accept)
            x_reg <= s_axis_tdata[W-1:0];

        if (state_reg == ST_HP_PREP)
        begin
            amp_reg  <= amp;
            clip_reg <= amp_clip;
            d_reg    <= hp_sum;
        end

        if (state_reg == ST_LP_PREP)
            diff_reg <= lp_diff;

        if (state_reg == ST_MUL_HI)
            lo_reg <= prod;

        if (state_reg == ST_LP_OUT && out_free)
        begin
            m_data_reg <= TDW'($unsigned(acc_int[W-1:0]));
            m_user_reg <= clip_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    `PGHL_ASSERT(a_accept_starts, clk, rst_n,
        accept |=> (state_reg == ST_MUL_GAIN) && !s_axis_tready)
    `PGHL_ASSERT(a_valid_from_last_step, clk, rst_n,
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_LP_OUT))
    `PGHL_ASSERT(a_hold_on_stall, clk, rst_n,
        (state_reg == ST_LP_OUT) && m_axis_tvalid && !m_axis_tready |=>
            (state_reg == ST_LP_OUT))
    `PGHL_NEVER(a_no_accept_busy, clk, rst_n,
        s_axis_tready && (state_reg != ST_IDLE))

endmodule
`default_nettype wire
